// File: hdl/ipv4fd_pkg.sv
package ipv4fd_pkg;

    localparam int ROUTE_ENTRIES = 16;
    localparam int INTERFACES    = 4;

    localparam int RT_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int IF_AW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
    localparam int CNT_W = (RT_AW > IF_AW) ? RT_AW : IF_AW;

    localparam logic [1:0] CMD_ROUTE_WR = 2'd0;
    localparam logic [1:0] CMD_IFACE_WR = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [1:0] KIND_PROTO = 2'd0;
    localparam logic [1:0] KIND_ECHO  = 2'd1;

    localparam logic [2:0] ACT_WRITTEN       = 3'd0;
    localparam logic [2:0] ACT_DROP          = 3'd1;
    localparam logic [2:0] ACT_FORWARD       = 3'd2;
    localparam logic [2:0] ACT_ECHO          = 3'd3;
    localparam logic [2:0] ACT_PORT_UNREACH  = 3'd4;
    localparam logic [2:0] ACT_TIME_EXCEEDED = 3'd5;
    localparam logic [2:0] ACT_DEST_UNREACH  = 3'd6;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } t_route;

    typedef struct packed {
        logic             en;
        logic [RT_AW-1:0] addr;
        logic             vld;
        t_route           entry;
    } t_rt_wr;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [RT_AW-1:0] addr;
        logic [31:0]      key;
    } t_rt_scan;

    typedef struct packed {
        logic             found;
        logic [RT_AW-1:0] idx;
        logic [31:0]      gateway;
        logic [1:0]       port;
    } t_rt_best;

endpackage

// File: hdl/ipv4fd_route_lpm.sv
module ipv4fd_route_lpm import ipv4fd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rt_wr   i_wr,
    input  t_rt_scan i_scan,
    output t_rt_best o_best
);

    t_route                   r_mem [ROUTE_ENTRIES];
    t_route                   r_rdata;
    logic [ROUTE_ENTRIES-1:0] r_vld;
    logic                     r_pend;
    logic [RT_AW-1:0]         r_pidx;
    logic                     r_found;
    logic [31:0]              r_best_mask;
    logic [RT_AW-1:0]         r_best_idx;
    logic [31:0]              r_best_gw;
    logic [1:0]               r_best_port;
    logic                     hit;
    logic                     better;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_scan.rd_en) begin
            r_rdata <= r_mem[i_scan.addr];
        end
        r_pidx <= i_scan.addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= i_wr.vld;
            end
            r_pend <= i_scan.rd_en;
        end
    end

    // entry read last cycle: match under its own mask, keep the longest
    assign hit    = r_pend && r_vld[r_pidx]
                    && (((r_rdata.prefix ^ i_scan.key) & r_rdata.mask) == 32'd0);
    assign better = hit && (!r_found || (r_rdata.mask > r_best_mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_scan.clear) begin
            r_found <= 1'b0;
        end else if (better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (better) begin
            r_best_mask <= r_rdata.mask;
            r_best_idx  <= r_pidx;
            r_best_gw   <= r_rdata.gateway;
            r_best_port <= r_rdata.port;
        end
    end

    assign o_best = '{found: r_found, idx: r_best_idx, gateway: r_best_gw,
                      port: r_best_port};

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_scan.rd_en |-> !i_wr.en)
        else $error("route write overlaps a table scan");

    a_better_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (better && !i_scan.clear) |=> r_found)
        else $error("matching route not recorded");

endmodule

// File: hdl/ipv4_forward_decision_unit.sv
// IPv4 forwarding decision unit.
// Input channel (i_valid / o_ready) carries one request per handshake: a route
// table write, an interface address write, or a classify request for one
// IPv4 header. Output channel (o_valid / i_ready) returns exactly one result
// per request, in order.
// Write requests: the table is written on the accepting edge; the result goes
// through S_FIN into the output register and is offered from there.
// Classify requests: the interface RAM is scanned one entry a cycle, then,
// when a lookup is needed, the route RAM one entry a cycle (single read port,
// registered read). The states run S_IFSCAN, S_IFLAST, S_DECIDE, then, for a
// lookup, S_RTSCAN, S_RTLAST and S_RESOLVE, and end in S_FIN, from which the
// result is loaded into the output register. o_ready rises the cycle
// after the result is loaded, so one request is in work at a time.
// Tables are written only while no scan runs, so reads and writes never meet.
// Reset clears all valid bits at once; table contents stay unwritten and are
// never seen while their valid bits are clear. No clearing pass is needed.
// When the receiver stalls, the result is held in the output register; the
// next request is still accepted and worked on, and waits only to deliver.
module ipv4_forward_decision_unit import ipv4fd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_index,
    input  logic        i_entry_valid,
    input  logic [31:0] i_route_prefix,
    input  logic [31:0] i_route_mask,
    input  logic [31:0] i_route_gateway,
    input  logic [1:0]  i_route_port,
    input  logic [31:0] i_iface_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_src_addr,
    input  logic [7:0]  i_ttl,
    input  logic [1:0]  i_packet_kind,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [31:0] o_next_hop,
    output logic [1:0]  o_out_port,
    output logic [7:0]  o_new_ttl,
    output logic [3:0]  o_route_index
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_IFSCAN  = 8'b0000_0010,
        S_IFLAST  = 8'b0000_0100,
        S_DECIDE  = 8'b0000_1000,
        S_RTSCAN  = 8'b0001_0000,
        S_RTLAST  = 8'b0010_0000,
        S_RESOLVE = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // request fields held for the scan
    logic [1:0]  r_port_in;
    logic [31:0] r_dst;
    logic [31:0] r_src;
    logic [7:0]  r_ttl;
    logic [1:0]  r_kind;
    logic [31:0] r_look_addr, n_look_addr;
    logic        r_look_echo, n_look_echo;

    // interface table and scan flags
    logic [31:0]           r_if_mem [INTERFACES];
    logic [31:0]           r_if_rdata;
    logic [INTERFACES-1:0] r_if_vld;
    logic                  r_if_pend;
    logic [IF_AW-1:0]      r_if_pidx;
    logic                  r_dst_local, n_dst_local;
    logic                  r_src_local, n_src_local;
    logic                  if_rd_en;

    // pending result
    logic [2:0]  r_res_action, n_res_action;
    logic [31:0] r_res_hop, n_res_hop;
    logic [1:0]  r_res_port, n_res_port;
    logic [7:0]  r_res_ttl, n_res_ttl;
    logic [3:0]  r_res_ridx, n_res_ridx;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_action;
    logic [31:0] r_out_hop;
    logic [1:0]  r_out_port;
    logic [7:0]  r_out_ttl;
    logic [3:0]  r_out_ridx;

    logic     accept;
    logic     load_out;
    t_rt_wr   rt_wr;
    t_rt_scan rt_scan;
    t_rt_best rt_best;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign if_rd_en = (r_state == S_IFSCAN);

    // Route table writes land on the accepting edge; out-of-range slots are ignored.
    assign rt_wr = '{en:    accept && (i_command == CMD_ROUTE_WR)
                            && (32'(i_index) < 32'(ROUTE_ENTRIES)),
                     addr:  RT_AW'(i_index),
                     vld:   i_entry_valid,
                     entry: '{prefix: i_route_prefix, mask: i_route_mask,
                              gateway: i_route_gateway, port: i_route_port}};

    assign rt_scan = '{clear: (r_state == S_DECIDE),
                       rd_en: (r_state == S_RTSCAN),
                       addr:  RT_AW'(r_cnt),
                       key:   r_look_addr};

    ipv4fd_route_lpm u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rt_wr),
        .i_scan  (rt_scan),
        .o_best  (rt_best)
    );

    // Interface RAM: written at acceptance, read one entry a cycle during the scan.
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_IFACE_WR) && (32'(i_index) < 32'(INTERFACES))) begin
            r_if_mem[IF_AW'(i_index)] <= i_iface_addr;
        end
        if (if_rd_en) begin
            r_if_rdata <= r_if_mem[IF_AW'(r_cnt)];
        end
        r_if_pidx <= IF_AW'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_vld  <= '0;
            r_if_pend <= 1'b0;
        end else begin
            if (accept && (i_command == CMD_IFACE_WR)
                    && (32'(i_index) < 32'(INTERFACES))) begin
                r_if_vld[IF_AW'(i_index)] <= i_entry_valid;
            end
            r_if_pend <= if_rd_en;
        end
    end

    // Hold the header fields of a classify request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_port_in <= i_index[1:0];
            r_dst     <= i_dst_addr;
            r_src     <= i_src_addr;
            r_ttl     <= i_ttl;
            r_kind    <= i_packet_kind;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_look_addr  = r_look_addr;
        n_look_echo  = r_look_echo;
        n_dst_local  = r_dst_local;
        n_src_local  = r_src_local;
        n_res_action = r_res_action;
        n_res_hop    = r_res_hop;
        n_res_port   = r_res_port;
        n_res_ttl    = r_res_ttl;
        n_res_ridx   = r_res_ridx;

        // fold in the interface entry read last cycle
        if (r_if_pend && r_if_vld[r_if_pidx]) begin
            if (r_if_rdata == r_dst) begin
                n_dst_local = 1'b1;
            end
            if (r_if_rdata == r_src) begin
                n_src_local = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    if (i_command == CMD_CLASSIFY) begin
                        n_dst_local = 1'b0;
                        n_src_local = 1'b0;
                        n_state     = S_IFSCAN;
                    end else begin
                        // writes and the unused command answer "written"
                        n_res_action = ACT_WRITTEN;
                        n_res_hop    = '0;
                        n_res_port   = '0;
                        n_res_ttl    = '0;
                        n_res_ridx   = '0;
                        n_state      = S_FIN;
                    end
                end
            end
            S_IFSCAN: begin
                if (r_cnt == CNT_W'(INTERFACES - 1)) begin
                    n_state = S_IFLAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IFLAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_cnt        = '0;
                n_res_hop    = '0;
                n_res_port   = '0;
                n_res_ttl    = r_ttl;
                n_res_ridx   = '0;
                n_res_action = ACT_DROP;
                n_state      = S_FIN;
                if (r_dst_local) begin
                    if (!r_src_local) begin
                        case (r_kind)
                            KIND_ECHO: begin
                                n_look_addr = r_src;
                                n_look_echo = 1'b1;
                                n_state     = S_RTSCAN;
                            end
                            KIND_PROTO: begin
                                n_res_action = ACT_PORT_UNREACH;
                                n_res_port   = r_port_in;
                            end
                            default: begin
                                n_res_action = ACT_DROP;
                            end
                        endcase
                    end
                end else if (r_ttl <= 8'd1) begin
                    n_res_action = ACT_TIME_EXCEEDED;
                    n_res_port   = r_port_in;
                end else begin
                    n_look_addr = r_dst;
                    n_look_echo = 1'b0;
                    n_state     = S_RTSCAN;
                end
            end
            S_RTSCAN: begin
                if (r_cnt == CNT_W'(ROUTE_ENTRIES - 1)) begin
                    n_state = S_RTLAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RTLAST: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                n_state = S_FIN;
                if (!rt_best.found) begin
                    n_res_action = r_look_echo ? ACT_DROP : ACT_DEST_UNREACH;
                    n_res_port   = r_look_echo ? 2'd0 : r_port_in;
                end else begin
                    n_res_action = r_look_echo ? ACT_ECHO : ACT_FORWARD;
                    n_res_hop    = (rt_best.gateway != 32'd0) ? rt_best.gateway
                                                              : r_look_addr;
                    n_res_port   = rt_best.port;
                    n_res_ttl    = r_look_echo ? r_ttl : (r_ttl - 8'd1);
                    n_res_ridx   = 4'(rt_best.idx);
                end
            end
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_look_addr  <= n_look_addr;
        r_look_echo  <= n_look_echo;
        r_dst_local  <= n_dst_local;
        r_src_local  <= n_src_local;
        r_res_action <= n_res_action;
        r_res_hop    <= n_res_hop;
        r_res_port   <= n_res_port;
        r_res_ttl    <= n_res_ttl;
        r_res_ridx   <= n_res_ridx;
    end

    // Output register: load when empty or being taken, drop valid once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_action <= r_res_action;
            r_out_hop    <= r_res_hop;
            r_out_port   <= r_res_port;
            r_out_ttl    <= r_res_ttl;
            r_out_ridx   <= r_res_ridx;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_action      = r_out_action;
    assign o_next_hop    = r_out_hop;
    assign o_out_port    = r_out_port;
    assign o_new_ttl     = r_out_ttl;
    assign o_route_index = r_out_ridx;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_load_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_valid && o_ready))
        else $error("loaded result not offered or sequencer not idle");

    a_forward_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_FORWARD)) |-> (o_new_ttl != 8'd0))
        else $error("forwarded header with expired TTL");

    a_written_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_WRITTEN))
            |-> ((o_next_hop == 32'd0) && (o_route_index == 4'd0) && (o_new_ttl == 8'd0)))
        else $error("write result carries non-zero fields");

endmodule

// File: tb/sv/tb_ipv4_forward_decision_unit.sv
`timescale 1ns / 1ps

import ipv4fd_pkg::*;

// Codes the package leaves unnamed
localparam logic [1:0] CMD_SPARE       = 2'd3;
localparam logic [1:0] KIND_OTHER_ICMP = 2'd2;
localparam logic [1:0] KIND_SPARE      = 2'd3;

typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  index;
    logic        entry_valid;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [1:0]  route_port;
    logic [31:0] iface_addr;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    logic [7:0]  ttl;
    logic [1:0]  packet_kind;
} t_fwd_req;

typedef struct packed {
    logic [2:0]  action;
    logic [31:0] next_hop;
    logic [1:0]  out_port;
    logic [7:0]  new_ttl;
    logic [3:0]  route_index;
} t_fwd_decision;

// Mirrors the route and interface tables and keeps the decisions still owed.
class t_fwd_decision_tracker;
    logic [31:0]   rt_prefix  [ROUTE_ENTRIES];
    logic [31:0]   rt_mask    [ROUTE_ENTRIES];
    logic [31:0]   rt_gateway [ROUTE_ENTRIES];
    logic [1:0]    rt_port    [ROUTE_ENTRIES];
    bit            rt_valid   [ROUTE_ENTRIES];
    logic [31:0]   if_addr    [INTERFACES];
    bit            if_valid   [INTERFACES];
    t_fwd_decision owed_decisions[$];
    int            fail_count;
    int            checked;
    int            requests;
    int            action_seen[8];

    function new();
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            rt_prefix[i]  = '0;
            rt_mask[i]    = '0;
            rt_gateway[i] = '0;
            rt_port[i]    = '0;
            rt_valid[i]   = 1'b0;
        end
        for (int i = 0; i < INTERFACES; i++) begin
            if_addr[i]  = '0;
            if_valid[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) action_seen[i] = 0;
        fail_count = 0;
        checked    = 0;
        requests   = 0;
    endfunction

    function bit is_local(logic [31:0] addr);
        for (int i = 0; i < INTERFACES; i++)
            if (if_valid[i] && if_addr[i] == addr) return 1'b1;
        return 1'b0;
    endfunction

    // Longest mask wins, numerically; the lowest slot keeps a tie.
    function bit find_route(logic [31:0] addr, output int slot);
        bit          found;
        logic [31:0] best_mask;
        found     = 1'b0;
        best_mask = '0;
        slot      = 0;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            if (rt_valid[i] && ((rt_prefix[i] & rt_mask[i]) == (addr & rt_mask[i]))) begin
                if (!found || rt_mask[i] > best_mask) begin
                    found     = 1'b1;
                    best_mask = rt_mask[i];
                    slot      = i;
                end
            end
        end
        return found;
    endfunction

    function t_fwd_decision decide(t_fwd_req r);
        t_fwd_decision d;
        int            slot;
        d = '0;
        case (r.command)
            CMD_ROUTE_WR: begin
                if (int'(r.index) < ROUTE_ENTRIES) begin
                    rt_prefix[r.index]  = r.route_prefix;
                    rt_mask[r.index]    = r.route_mask;
                    rt_gateway[r.index] = r.route_gateway;
                    rt_port[r.index]    = r.route_port;
                    rt_valid[r.index]   = r.entry_valid;
                end
            end
            CMD_IFACE_WR: begin
                if (int'(r.index) < INTERFACES) begin
                    if_addr[r.index[IF_AW-1:0]]  = r.iface_addr;
                    if_valid[r.index[IF_AW-1:0]] = r.entry_valid;
                end
            end
            CMD_CLASSIFY: begin
                d.new_ttl = r.ttl;
                if (is_local(r.dst_addr)) begin
                    if (is_local(r.src_addr)) begin
                        d.action = ACT_DROP;
                    end else if (r.packet_kind == KIND_ECHO) begin
                        if (find_route(r.src_addr, slot)) begin
                            d.action      = ACT_ECHO;
                            d.next_hop    = (rt_gateway[slot] != '0) ? rt_gateway[slot]
                                                                     : r.src_addr;
                            d.out_port    = rt_port[slot];
                            d.route_index = 4'(slot);
                        end else begin
                            d.action = ACT_DROP;
                        end
                    end else if (r.packet_kind == KIND_PROTO) begin
                        d.action   = ACT_PORT_UNREACH;
                        d.out_port = r.index[1:0];
                    end else begin
                        d.action = ACT_DROP;
                    end
                end else if (r.ttl <= 8'd1) begin
                    d.action   = ACT_TIME_EXCEEDED;
                    d.out_port = r.index[1:0];
                end else if (!find_route(r.dst_addr, slot)) begin
                    d.action   = ACT_DEST_UNREACH;
                    d.out_port = r.index[1:0];
                end else begin
                    d.action      = ACT_FORWARD;
                    d.next_hop    = (rt_gateway[slot] != '0) ? rt_gateway[slot] : r.dst_addr;
                    d.out_port    = rt_port[slot];
                    d.new_ttl     = r.ttl - 8'd1;
                    d.route_index = 4'(slot);
                end
            end
            default: ;
        endcase
        return d;
    endfunction

    function void note_request(t_fwd_req r);
        owed_decisions.push_back(decide(r));
        requests++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function void check_decision(t_fwd_decision got);
        t_fwd_decision want;
        if (owed_decisions.size() == 0) begin
            $error("result with no request waiting: action %0d", got.action);
            fail_count++;
            return;
        end
        want = owed_decisions.pop_front();
        compare_field("action", 32'(want.action), 32'(got.action));
        compare_field("next_hop", want.next_hop, got.next_hop);
        compare_field("out_port", 32'(want.out_port), 32'(got.out_port));
        compare_field("new_ttl", 32'(want.new_ttl), 32'(got.new_ttl));
        compare_field("route_index", 32'(want.route_index), 32'(got.route_index));
        action_seen[want.action]++;
        checked++;
    endfunction

    function int owed_count();
        return owed_decisions.size();
    endfunction
endclass

module tb_ipv4_forward_decision_unit;

    localparam int RANDOM_REQUESTS = 530;
    localparam int CYCLE_LIMIT     = 400_000;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 40;

    typedef enum int {RX_EAGER, RX_COIN, RX_MOSTLY, RX_PULSED} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [3:0]  i_index;
    logic        i_entry_valid;
    logic [31:0] i_route_prefix;
    logic [31:0] i_route_mask;
    logic [31:0] i_route_gateway;
    logic [1:0]  i_route_port;
    logic [31:0] i_iface_addr;
    logic [31:0] i_dst_addr;
    logic [31:0] i_src_addr;
    logic [7:0]  i_ttl;
    logic [1:0]  i_packet_kind;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_action;
    logic [31:0] o_next_hop;
    logic [1:0]  o_out_port;
    logic [7:0]  o_new_ttl;
    logic [3:0]  o_route_index;

    t_fwd_decision_tracker tracker = new();

    // Set once by the request side to make the result side hold off for a long stretch
    bit          long_hold_req = 1'b0;
    int          cycle_count   = 0;

    // Network bases that routes and addresses are drawn around, so lookups hit
    logic [31:0] net_base     [8];
    // Last addresses written to interface slots, to aim packets at local hosts
    logic [31:0] iface_shadow [4];

    ipv4_forward_decision_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_index         (i_index),
        .i_entry_valid   (i_entry_valid),
        .i_route_prefix  (i_route_prefix),
        .i_route_mask    (i_route_mask),
        .i_route_gateway (i_route_gateway),
        .i_route_port    (i_route_port),
        .i_iface_addr    (i_iface_addr),
        .i_dst_addr      (i_dst_addr),
        .i_src_addr      (i_src_addr),
        .i_ttl           (i_ttl),
        .i_packet_kind   (i_packet_kind),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_next_hop      (o_next_hop),
        .o_out_port      (o_out_port),
        .o_new_ttl       (o_new_ttl),
        .o_route_index   (o_route_index)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_ipv4_forward_decision_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------

    // Fill every field with noise; callers then set what the command uses.
    function automatic t_fwd_req noisy_request();
        t_fwd_req r;
        r.command       = 2'($urandom);
        r.index         = 4'($urandom);
        r.entry_valid   = 1'($urandom);
        r.route_prefix  = $urandom;
        r.route_mask    = $urandom;
        r.route_gateway = $urandom;
        r.route_port    = 2'($urandom);
        r.iface_addr    = $urandom;
        r.dst_addr      = $urandom;
        r.src_addr      = $urandom;
        r.ttl           = 8'($urandom);
        r.packet_kind   = 2'($urandom);
        return r;
    endfunction

    function automatic t_fwd_req route_req(logic [3:0] slot, logic vld, logic [31:0] prefix,
                                           logic [31:0] mask, logic [31:0] gw, logic [1:0] port);
        t_fwd_req r;
        r               = noisy_request();
        r.command       = CMD_ROUTE_WR;
        r.index         = slot;
        r.entry_valid   = vld;
        r.route_prefix  = prefix;
        r.route_mask    = mask;
        r.route_gateway = gw;
        r.route_port    = port;
        return r;
    endfunction

    function automatic t_fwd_req iface_req(logic [3:0] slot, logic vld, logic [31:0] addr);
        t_fwd_req r;
        r             = noisy_request();
        r.command     = CMD_IFACE_WR;
        r.index       = slot;
        r.entry_valid = vld;
        r.iface_addr  = addr;
        if (slot < 4) iface_shadow[slot[1:0]] = addr;
        return r;
    endfunction

    function automatic t_fwd_req classify_req(logic [3:0] arrival, logic [31:0] dst,
                                              logic [31:0] src, logic [7:0] ttl,
                                              logic [1:0] kind);
        t_fwd_req r;
        r             = noisy_request();
        r.command     = CMD_CLASSIFY;
        r.index       = arrival;
        r.dst_addr    = dst;
        r.src_addr    = src;
        r.ttl         = ttl;
        r.packet_kind = kind;
        return r;
    endfunction

    // An address close to one of the network bases: flip up to 20 low bits.
    function automatic logic [31:0] near_addr();
        int          nbits;
        logic [31:0] low;
        nbits = $urandom_range(0, 20);
        low   = $urandom & ((32'h1 << nbits) - 32'h1);
        return net_base[$urandom_range(0, 7)] ^ low;
    endfunction

    // Mostly contiguous netmasks of any length; now and then an arbitrary one.
    function automatic logic [31:0] pick_mask();
        int len;
        if ($urandom_range(0, 9) == 0) return $urandom;
        len = $urandom_range(0, 32);
        if (len == 0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic logic [31:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return iface_shadow[$urandom_range(0, 3)];
        if (sel < 8) return near_addr();
        return $urandom;
    endfunction

    function automatic t_fwd_req random_request();
        t_fwd_req r;
        int       sel;
        r   = noisy_request();
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
            r = route_req(4'($urandom), ($urandom_range(0, 9) != 0), near_addr(), pick_mask(),
                          ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom, 2'($urandom));
        end else if (sel < 28) begin
            r = iface_req(($urandom_range(0, 4) == 0) ? 4'($urandom_range(4, 15))
                                                      : 4'($urandom_range(0, 3)),
                          ($urandom_range(0, 9) != 0), near_addr());
        end else if (sel < 31) begin
            r.command = CMD_SPARE;
        end else begin
            r = classify_req(4'($urandom), pick_addr(), pick_addr(),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2))
                                                         : 8'($urandom),
                             2'($urandom_range(0, 3)));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request channel
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Valid stays high
    // on return; rest() lowers it when a gap follows.
    task automatic offer(input t_fwd_req r);
        i_valid         <= 1'b1;
        i_command       <= r.command;
        i_index         <= r.index;
        i_entry_valid   <= r.entry_valid;
        i_route_prefix  <= r.route_prefix;
        i_route_mask    <= r.route_mask;
        i_route_gateway <= r.route_gateway;
        i_route_port    <= r.route_port;
        i_iface_addr    <= r.iface_addr;
        i_dst_addr      <= r.dst_addr;
        i_src_addr      <= r.src_addr;
        i_ttl           <= r.ttl;
        i_packet_kind   <= r.packet_kind;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(r);
    endtask

    task automatic rest(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the request side until every owed decision has come back.
    task automatic drain();
        rest(1);
        while (tracker.owed_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        int       burst_left;
        t_fwd_req r;

        // Drive every input to a known value and hold reset
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_command       <= '0;
        i_index         <= '0;
        i_entry_valid   <= 1'b0;
        i_route_prefix  <= '0;
        i_route_mask    <= '0;
        i_route_gateway <= '0;
        i_route_port    <= '0;
        i_iface_addr    <= '0;
        i_dst_addr      <= '0;
        i_src_addr      <= '0;
        i_ttl           <= '0;
        i_packet_kind   <= '0;
        for (int i = 0; i < 8; i++) net_base[i] = $urandom;
        for (int i = 0; i < 4; i++) iface_shadow[i] = net_base[i];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- Directed part ---
        // Empty tables: expired TTL, then no route at all
        r = '0;
        r.command = CMD_CLASSIFY;
        offer(r);
        offer(classify_req(4'd2, 32'h0808_0808, 32'h0101_0101, 8'd255, KIND_PROTO));
        // Two local interfaces, one write past the last slot, one spare command
        offer(iface_req(4'd0, 1'b1, 32'h0A00_0001));
        offer(iface_req(4'd1, 1'b1, 32'hC0A8_0101));
        offer(iface_req(4'd5, 1'b1, 32'h0808_0808));
        r = '1;
        r.command = CMD_SPARE;
        offer(r);
        // Local to local drops; echo with no route back drops
        offer(classify_req(4'd1, 32'h0A00_0001, 32'hC0A8_0101, 8'd64, KIND_ECHO));
        offer(classify_req(4'd1, 32'h0A00_0001, 32'h0A01_0207, 8'd64, KIND_ECHO));
        // Local, non-ICMP: port unreachable on the arrival port's low bits; other kinds drop
        offer(classify_req(4'd15, 32'hC0A8_0101, 32'h0303_0303, 8'd0, KIND_PROTO));
        offer(classify_req(4'd3, 32'hC0A8_0101, 32'h0303_0303, 8'd9, KIND_OTHER_ICMP));
        offer(classify_req(4'd3, 32'hC0A8_0101, 32'h0303_0303, 8'd9, KIND_SPARE));
        // Routes: /16, two /24 ties, host route at the top slot, default route
        offer(route_req(4'd3, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 2'd2));
        offer(route_req(4'd5, 1'b1, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_0002, 2'd1));
        offer(route_req(4'd7, 1'b1, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_0003, 2'd3));
        offer(route_req(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
        offer(route_req(4'd0, 1'b1, 32'h0, 32'h0, 32'h0102_0304, 2'd0));
        // Forward: tie to the lower slot, direct route, host route, default route
        offer(classify_req(4'd0, 32'h0A01_0209, 32'h0505_0505, 8'd2, KIND_PROTO));
        offer(classify_req(4'd0, 32'h0A01_0909, 32'h0505_0505, 8'd255, KIND_ECHO));
        offer(classify_req(4'd0, 32'hFFFF_FFFF, 32'h0, 8'd128, KIND_PROTO));
        offer(classify_req(4'd0, 32'h0808_0808, 32'h0, 8'd10, KIND_PROTO));
        // Echo reply routed back to the source, then an expired TTL on a transit packet
        offer(classify_req(4'd2, 32'h0A00_0001, 32'h0A01_0207, 8'd1, KIND_ECHO));
        offer(classify_req(4'd6, 32'h0A01_0209, 32'h0, 8'd1, KIND_PROTO));
        // Invalidate the default route and retry
        offer(route_req(4'd0, 1'b0, 32'h0, 32'h0, 32'h0102_0304, 2'd0));
        offer(classify_req(4'd6, 32'h0808_0808, 32'h0, 8'd10, KIND_PROTO));

        // --- Random part: bursts with random gaps ---
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 150) long_hold_req = 1'b1;
            if (n == 350) drain();
            offer(random_request());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 30));
            end
        end

        // Wait for the last decisions, then let the block settle
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked decisions.",
                 tracker.requests, tracker.checked);
        $display("Decisions: written %0d, drop %0d, forward %0d, echo %0d, port unreach %0d, %s",
                 tracker.action_seen[ACT_WRITTEN], tracker.action_seen[ACT_DROP],
                 tracker.action_seen[ACT_FORWARD], tracker.action_seen[ACT_ECHO],
                 tracker.action_seen[ACT_PORT_UNREACH],
                 $sformatf("ttl expired %0d, no route %0d",
                           tracker.action_seen[ACT_TIME_EXCEEDED],
                           tracker.action_seen[ACT_DEST_UNREACH]));
        if (tracker.fail_count == 0 && tracker.owed_count() == 0) begin
            $display("tb_ipv4_forward_decision_unit passed");
        end else begin
            $display("tb_ipv4_forward_decision_unit failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result channel: check each accepted decision, stall on a pattern
    // ------------------------------------------------------------------
    initial begin
        t_rx_mode      mode;
        int            mode_left;
        int            phase;
        int            hold_left;
        bit            hold_taken;
        t_fwd_decision got;

        mode       = RX_EAGER;
        mode_left  = 0;
        phase      = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.action      = o_action;
                got.next_hop    = o_next_hop;
                got.out_port    = o_out_port;
                got.new_ttl     = o_new_ttl;
                got.route_index = o_route_index;
                tracker.check_decision(got);
            end
            // Switch stall pattern now and then
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            // Take the long hold-off once, while requests keep coming
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_EAGER:  i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: i_ready <= ($urandom_range(0, 4) != 0);
                    default:   i_ready <= ((phase % 8) < 3);
                endcase
            end
        end
    end

endmodule

// File: files.f
hdl/ipv4fd_pkg.sv
hdl/ipv4fd_route_lpm.sv
hdl/ipv4_forward_decision_unit.sv
tb/sv/tb_ipv4_forward_decision_unit.sv
